[rtl/keypad_word_trie_predictor_unit_assert.svh]
// Assertion macros for the trie predictor.
// Compiled out when SYNTH is defined.
`ifndef KEYPAD_WORD_TRIE_PREDICTOR_UNIT_ASSERT_SVH
`define KEYPAD_WORD_TRIE_PREDICTOR_UNIT_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define KWTP_ASSERT_IMPLY(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KWTP_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KWTP_ASSERT_IMPLY(name, clk, rstn, ante, cons, msg)
`define KWTP_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)

`endif

`endif

[rtl/kwtp_pkg.sv]
package kwtp_pkg;

  localparam int MaxNodes       = 8192;
  localparam int MaxChildren    = 8;
  localparam int MaxSets        = 4096;
  localparam int MaxWordsPerSet = 16;
  localparam int ResultCap      = 16;

  localparam int TrieCols  = 2 + 2 * MaxChildren;
  localparam int SetCols   = 1 + MaxWordsPerSet;
  localparam int TrieDepth = MaxNodes * TrieCols;
  localparam int SugDepth  = MaxSets * SetCols;
  localparam int TrieAw    = $clog2(TrieDepth);
  localparam int SugAw     = $clog2(SugDepth);
  localparam int NodeW     = $clog2(MaxNodes);
  localparam int SetW      = $clog2(MaxSets);
  localparam int TColW     = $clog2(TrieCols);
  localparam int SColW     = $clog2(SetCols);

  // Pair scan: count of pairs (0..MaxChildren) and pair index.
  localparam int PairW = $clog2(MaxChildren + 1);
  localparam int IdxW  = (MaxChildren > 1) ? $clog2(MaxChildren) : 1;

  // Word run: count of words (0..WordCap) and word index.
  localparam int WordCap = (MaxWordsPerSet < ResultCap) ? MaxWordsPerSet : ResultCap;
  localparam int NwW     = $clog2(WordCap + 1);
  localparam int WkW     = (WordCap > 1) ? $clog2(WordCap) : 1;

  typedef enum logic [1:0] {
    FnKey    = 2'd0,
    FnCommit = 2'd1,
    FnTrieWr = 2'd2,
    FnSugWr  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    StSuggest = 3'd0,
    StNoMatch = 3'd1,
    StEmpty   = 3'd2,
    StCommit  = 3'd3,
    StNothing = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT,
    S_SYM,
    S_CHILD,
    S_SETRQ,
    S_SET,
    S_WCNT,
    S_WORD,
    S_CSET,
    S_CCNT,
    S_CWORD,
    S_ONE
  } state_e;

  // A set number is usable when it is non-negative and inside the set store.
  function automatic logic set_ok(logic [15:0] raw);
    return !raw[15] && (32'(raw) < MaxSets);
  endfunction

endpackage

[rtl/keypad_word_trie_predictor_unit.sv]
// Keypad predictive-text engine. Writes (func 2, func 3) load a trie store of
// MaxNodes rows x 18 words and a suggestion store of MaxSets rows x 17 words;
// both are single-port-write, single-port-read synchronous memories with no
// reset, so every entry must be written before any key or commit reaches it.
// A key word scans the current node's (symbol, child) pairs one pair per
// cycle, moves to the matching child and streams that node's word indices one
// per cycle while the output is not stalled, the final one flagged with last;
// a failed scan gives one no-match result, a child without words one empty
// result. A commit gives the first word of the current node's set (or a
// nothing-to-commit status) and returns to the root. Each memory has a
// single read port, so every trie word and every suggestion word is read on
// its own. A finished result sits in the output register, so the next word
// is accepted while it waits to be taken.
`include "keypad_word_trie_predictor_unit_assert.svh"

module keypad_word_trie_predictor_unit
  import kwtp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [3:0]         key_symbol_i,
  input  logic [12:0]        row_index_i,
  input  logic [4:0]         column_index_i,
  input  logic signed [15:0] write_value_i,

  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [15:0]        word_index_o,
  output logic               last_o
);

  // Control state
  state_e             state_q, state_d;
  logic [NodeW-1:0]   cur_node_q, cur_node_d;
  logic               out_valid_q;

  // Working registers of one item
  logic [3:0]         key_q, key_d;
  logic [PairW-1:0]   pairs_q, pairs_d;
  logic [IdxW-1:0]    pair_q, pair_d;
  logic [SetW-1:0]    set_q, set_d;
  logic [NwW-1:0]     nwords_q, nwords_d;
  logic [WkW-1:0]     wk_q, wk_d;
  status_e            res_q, res_d;

  // Output register payload
  status_e            status_q;
  logic [15:0]        word_q;
  logic               last_q;

  // Memories
  logic [15:0]        trie_mem [TrieDepth];
  logic [15:0]        sug_mem  [SugDepth];
  logic [15:0]        trie_rdata_q;
  logic [15:0]        sug_rdata_q;
  logic [TrieAw-1:0]  trie_raddr, trie_waddr;
  logic [SugAw-1:0]   sug_raddr, sug_waddr;
  logic [TColW-1:0]   trie_col;
  logic [SColW-1:0]   sug_col;
  logic               trie_we, sug_we;

  // Handshake and emit
  logic               in_acc;
  logic               out_free;
  logic               emit_valid;
  status_e            emit_status;
  logic [15:0]        emit_word;
  logic               emit_last;

  // Helpers
  logic [PairW-1:0]   npairs;
  logic [PairW-1:0]   pair_ext, pair_next;
  logic [NwW-1:0]     nwords_cap;
  logic [NwW-1:0]     wk_ext, wk_next;
  logic               sym_hit;
  logic               word_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign pair_ext  = PairW'(pair_q);
  assign pair_next = pair_ext + PairW'(1);
  assign wk_ext    = NwW'(wk_q);
  assign wk_next   = wk_ext + NwW'(1);
  assign word_last = (wk_next == nwords_q);
  assign sym_hit   = (trie_rdata_q == {12'd0, key_q});

  // Pair count: negative scans nothing, large values clamp to the row size.
  always_comb begin
    if (trie_rdata_q[15]) begin
      npairs = '0;
    end else if (32'(trie_rdata_q) > MaxChildren) begin
      npairs = PairW'(MaxChildren);
    end else begin
      npairs = trie_rdata_q[PairW-1:0];
    end
  end

  // Word count: read unsigned, clamp to the run length.
  always_comb begin
    if (32'(sug_rdata_q) > WordCap) begin
      nwords_cap = NwW'(WordCap);
    end else begin
      nwords_cap = sug_rdata_q[NwW-1:0];
    end
  end

  // Addresses: row * columns + column, constant multiplies.
  assign trie_raddr = TrieAw'(cur_node_q) * TrieAw'(TrieCols) + TrieAw'(trie_col);
  assign sug_raddr  = SugAw'(set_d) * SugAw'(SetCols) + SugAw'(sug_col);
  assign trie_waddr = TrieAw'(row_index_i) * TrieAw'(TrieCols) + TrieAw'(column_index_i);
  assign sug_waddr  = SugAw'(row_index_i) * SugAw'(SetCols) + SugAw'(column_index_i);

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    cur_node_d  = cur_node_q;
    key_d       = key_q;
    pairs_d     = pairs_q;
    pair_d      = pair_q;
    set_d       = set_q;
    nwords_d    = nwords_q;
    wk_d        = wk_q;
    res_d       = res_q;
    trie_col    = '0;
    sug_col     = '0;
    trie_we     = 1'b0;
    sug_we      = 1'b0;
    emit_valid  = 1'b0;
    emit_status = StSuggest;
    emit_word   = '0;
    emit_last   = 1'b1;

    case (state_q)
      S_IDLE: begin
        // Keep the current node's row head in flight; a key needs the
        // pair count, a commit needs the set number.
        trie_col = (func_e'(func_i) == FnKey) ? TColW'(1) : '0;
        if (in_acc) begin
          key_d = key_symbol_i;
          case (func_e'(func_i))
            FnKey: begin
              state_d = S_CNT;
            end
            FnCommit: begin
              cur_node_d = '0;
              state_d    = S_CSET;
            end
            FnTrieWr: begin
              trie_we = (32'(row_index_i) < MaxNodes) &&
                        (32'(column_index_i) < TrieCols);
            end
            FnSugWr: begin
              sug_we = (32'(row_index_i) < MaxSets) &&
                       (32'(column_index_i) < SetCols);
            end
            default: ;
          endcase
        end
      end

      S_CNT: begin
        pairs_d  = npairs;
        pair_d   = '0;
        trie_col = TColW'(2);
        if (npairs == '0) begin
          res_d   = StNoMatch;
          state_d = S_ONE;
        end else begin
          state_d = S_SYM;
        end
      end

      S_SYM: begin
        if (sym_hit) begin
          trie_col = TColW'(3 + 2 * int'(pair_q));
          state_d  = S_CHILD;
        end else if (pair_next == pairs_q) begin
          res_d   = StNoMatch;
          state_d = S_ONE;
        end else begin
          pair_d   = pair_q + IdxW'(1);
          trie_col = TColW'(2 + 2 * int'(pair_next));
        end
      end

      S_CHILD: begin
        // A child outside the trie counts as no match and keeps the node.
        if (32'(trie_rdata_q) >= MaxNodes) begin
          res_d   = StNoMatch;
          state_d = S_ONE;
        end else begin
          cur_node_d = trie_rdata_q[NodeW-1:0];
          state_d    = S_SETRQ;
        end
      end

      S_SETRQ: begin
        trie_col = '0;
        state_d  = S_SET;
      end

      S_SET: begin
        if (!set_ok(trie_rdata_q)) begin
          res_d   = StEmpty;
          state_d = S_ONE;
        end else begin
          set_d   = trie_rdata_q[SetW-1:0];
          sug_col = '0;
          state_d = S_WCNT;
        end
      end

      S_WCNT: begin
        nwords_d = nwords_cap;
        wk_d     = '0;
        sug_col  = SColW'(1);
        if (nwords_cap == '0) begin
          res_d   = StEmpty;
          state_d = S_ONE;
        end else begin
          state_d = S_WORD;
        end
      end

      S_WORD: begin
        emit_valid  = out_free;
        emit_status = StSuggest;
        emit_word   = sug_rdata_q;
        emit_last   = word_last;
        // Hold the read on this word while stalled, else fetch the next.
        sug_col     = SColW'(1) + SColW'(wk_ext);
        if (out_free) begin
          if (word_last) begin
            state_d = S_IDLE;
          end else begin
            wk_d    = wk_q + WkW'(1);
            sug_col = SColW'(1) + SColW'(wk_next);
          end
        end
      end

      S_CSET: begin
        if (!set_ok(trie_rdata_q)) begin
          res_d   = StNothing;
          state_d = S_ONE;
        end else begin
          set_d   = trie_rdata_q[SetW-1:0];
          sug_col = '0;
          state_d = S_CCNT;
        end
      end

      S_CCNT: begin
        sug_col = SColW'(1);
        if (sug_rdata_q == '0) begin
          res_d   = StNothing;
          state_d = S_ONE;
        end else begin
          state_d = S_CWORD;
        end
      end

      S_CWORD: begin
        sug_col     = SColW'(1);
        emit_valid  = out_free;
        emit_status = StCommit;
        emit_word   = sug_rdata_q;
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      S_ONE: begin
        emit_valid  = out_free;
        emit_status = res_q;
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_node_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_node_q <= cur_node_d;
      if (emit_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    pairs_q  <= pairs_d;
    pair_q   <= pair_d;
    set_q    <= set_d;
    nwords_q <= nwords_d;
    wk_q     <= wk_d;
    res_q    <= res_d;
    if (emit_valid) begin
      status_q <= emit_status;
      word_q   <= emit_word;
      last_q   <= emit_last;
    end
  end

  // Trie store
  always_ff @(posedge clk_i) begin
    if (trie_we) begin
      trie_mem[trie_waddr] <= $unsigned(write_value_i);
    end
    trie_rdata_q <= trie_mem[trie_raddr];
  end

  // Suggestion store
  always_ff @(posedge clk_i) begin
    if (sug_we) begin
      sug_mem[sug_waddr] <= $unsigned(write_value_i);
    end
    sug_rdata_q <= sug_mem[sug_raddr];
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign word_index_o = word_q;
  assign last_o       = last_q;

  `KWTP_ASSERT_IMPLY(a_scan_bound, clk_i, rst_ni, state_q == S_SYM, pair_ext < pairs_q, "pair scan ran past the pair count")
  `KWTP_ASSERT_IMPLY(a_run_bound, clk_i, rst_ni, state_q == S_WORD, (wk_ext < nwords_q) && (nwords_q <= NwW'(WordCap)), "word run ran past its count")
  `KWTP_ASSERT_IMPLY(a_emit_free, clk_i, rst_ni, emit_valid, !out_valid_q || !out_stall_i, "result overwrote a stalled result")
  `KWTP_ASSERT_NEXT(a_commit_root, clk_i, rst_ni, in_acc && (func_i == FnCommit), (cur_node_q == '0) && (state_q == S_CSET), "commit did not return to the root")

endmodule

[sim/tb_keypad_word_trie_predictor_unit.sv]
module tb_keypad_word_trie_predictor_unit;
  import kwtp_pkg::*;

  // One word on the input channel: a key, a commit or a table write.
  typedef struct {
    func_e       func;
    logic [3:0]  sym;
    logic [12:0] row;
    logic [4:0]  col;
    logic [15:0] val;
  } key_word_t;

  // One result on the output channel.
  typedef struct {
    status_e     status;
    logic [15:0] word;
    logic        last;
  } suggestion_t;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  localparam int RandomWords = 80;
  localparam int LongHold    = 400;
  localparam int DrainCycles = 40;
  localparam int CycleLimit  = 400000;

  // Trie nodes built at load time. Every column of these rows is written, and
  // every child pointer ever stored names one of them or lies past the store,
  // so a walk never touches an entry that was not written.
  localparam int NodeRoot  = 0;
  localparam int NodeTop   = MaxNodes - 1;
  localparam int NodeDead  = 4097;
  localparam int NodeQuiet = 1234;
  localparam int NodeLong  = 6000;
  localparam int NodeLeaf  = 77;

  // Suggestion sets built at load time, also written in full.
  localparam int SetOne   = 0;
  localparam int SetFull  = MaxSets - 1;
  localparam int SetEmpty = 2049;
  localparam int SetHuge  = 100;

  int live_nodes [6] = '{NodeRoot, NodeTop, NodeDead, NodeQuiet, NodeLong, NodeLeaf};
  int live_sets  [4] = '{SetOne, SetFull, SetEmpty, SetHuge};

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  func_e       func         = FnKey;
  logic [3:0]  key_symbol   = '0;
  logic [12:0] row_index    = '0;
  logic [4:0]  column_index = '0;
  logic [15:0] write_value  = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [2:0]  status;
  logic [15:0] word_index;
  logic        last;

  keypad_word_trie_predictor_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .key_symbol_i   (key_symbol),
    .row_index_i    (row_index),
    .column_index_i (column_index),
    .write_value_i  (write_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .word_index_o   (word_index),
    .last_o         (last)
  );

  // Shadow of the block: current node plus both tables, indexed row * cols + col.
  logic [NodeW-1:0] cursor_node = '0;
  logic [15:0]      trie_rows [int];
  logic [15:0]      set_rows  [int];

  key_word_t   pending_words [$];
  suggestion_t expected_suggestions [$];

  key_word_t   offered;
  suggestion_t exp_res;
  int          words_queued  = 0;
  int          words_taken   = 0;
  int          burst_left    = 0;
  int          gap_left      = 0;
  int          hold_left     = 0;
  int          mode_left     = 0;
  int          hold_at       = 32'h7fff_ffff;
  bit          long_hold_done = 1'b0;
  stall_mode_e stall_mode    = StallNone;
  int          cycle_cnt     = 0;
  int          mismatch_cnt  = 0;
  int          results_checked = 0;
  int          keys_taken    = 0;
  int          commits_taken = 0;
  int          writes_taken  = 0;
  int          runs_seen     = 0;
  int          no_match_seen = 0;
  int          commits_seen  = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  task automatic expect_result(status_e s, logic [15:0] w, logic l);
    suggestion_t r;
    r.status = s;
    r.word   = w;
    r.last   = l;
    expected_suggestions.push_back(r);
  endtask

  // Set number held by a node, or -1 when it names no set.
  function automatic int node_set_of(int node);
    logic [15:0] raw;
    raw = trie_rows[node * TrieCols];
    if (raw[15] || raw >= MaxSets) return -1;
    return int'(raw);
  endfunction

  // Apply one accepted word to the shadow state and queue the results it causes.
  task automatic walk_trie(key_word_t w);
    int          base;
    int          set_no;
    int          pairs;
    int          nwords;
    bit          hit;
    logic [15:0] raw;
    logic [15:0] child;
    base = int'(cursor_node) * TrieCols;
    hit  = 1'b0;
    case (w.func)
      FnTrieWr: begin
        if (int'(w.row) < MaxNodes && int'(w.col) < TrieCols)
          trie_rows[int'(w.row) * TrieCols + int'(w.col)] = w.val;
      end
      FnSugWr: begin
        if (int'(w.row) < MaxSets && int'(w.col) < SetCols)
          set_rows[int'(w.row) * SetCols + int'(w.col)] = w.val;
      end
      FnCommit: begin
        // Return to the root whether or not a word goes out.
        set_no      = node_set_of(int'(cursor_node));
        cursor_node = '0;
        if (set_no < 0 || set_rows[set_no * SetCols] == 16'd0)
          expect_result(StNothing, 16'd0, 1'b1);
        else
          expect_result(StCommit, set_rows[set_no * SetCols + 1], 1'b1);
      end
      default: begin
        // Negative descendant count scans nothing; large counts clamp.
        raw   = trie_rows[base + 1];
        pairs = raw[15] ? 0 : int'(raw);
        if (pairs > MaxChildren) pairs = MaxChildren;
        for (int i = 0; i < pairs && !hit; i++) begin
          if (trie_rows[base + 2 + 2 * i] == {12'd0, w.sym}) begin
            hit   = 1'b1;
            child = trie_rows[base + 3 + 2 * i];
            if (child >= MaxNodes) begin
              // Child beyond the store: keep the node, report no match.
              expect_result(StNoMatch, 16'd0, 1'b1);
            end else begin
              cursor_node = child[NodeW-1:0];
              set_no      = node_set_of(int'(child));
              nwords      = 0;
              if (set_no >= 0) begin
                raw    = set_rows[set_no * SetCols];
                nwords = (raw > MaxWordsPerSet) ? MaxWordsPerSet : int'(raw);
                if (nwords > ResultCap) nwords = ResultCap;
              end
              if (nwords == 0)
                expect_result(StEmpty, 16'd0, 1'b1);
              for (int k = 0; k < nwords; k++)
                expect_result(StSuggest, set_rows[set_no * SetCols + 1 + k],
                              k == nwords - 1);
            end
          end
        end
        if (!hit) expect_result(StNoMatch, 16'd0, 1'b1);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_word(func_e f, int row, int col, logic [15:0] v, logic [3:0] sym);
    key_word_t w;
    w.func = f;
    w.sym  = sym;
    w.row  = 13'(row);
    w.col  = 5'(col);
    w.val  = v;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // Unused fields carry random bits so the block must ignore them.
  task automatic push_key(logic [3:0] sym);
    push_word(FnKey, $urandom_range(0, 8191), $urandom_range(0, 31), 16'($urandom), sym);
  endtask

  task automatic push_commit();
    push_word(FnCommit, $urandom_range(0, 8191), $urandom_range(0, 31), 16'($urandom),
              4'($urandom));
  endtask

  task automatic push_write(func_e f, int row, int col, logic [15:0] v);
    push_word(f, row, col, v, 4'($urandom));
  endtask

  function automatic logic [15:0] pick_child();
    if ($urandom_range(0, 4) == 0) return 16'($urandom_range(MaxNodes, 65535));
    return 16'(live_nodes[$urandom_range(0, 5)]);
  endfunction

  // A value for a trie column that keeps every walk on written entries.
  function automatic logic [15:0] pick_trie_value(int col);
    int r;
    r = $urandom_range(0, 9);
    if (col == 0) begin
      if (r < 6) return 16'(live_sets[$urandom_range(0, 3)]);
      if (r < 8) return 16'h8000 | 16'($urandom);
      return 16'($urandom_range(MaxSets, 32767));
    end
    if (col == 1) begin
      if (r < 7) return 16'($urandom_range(0, MaxChildren));
      if (r < 9) return 16'($urandom_range(MaxChildren + 1, 32767));
      return 16'h8000 | 16'($urandom);
    end
    if (col % 2 == 0) begin
      if (r < 8) return 16'($urandom_range(0, 15));
      return {12'($urandom_range(1, 4095)), 4'($urandom)};
    end
    return pick_child();
  endfunction

  function automatic logic [15:0] pick_set_value(int col);
    if (col != 0) return 16'($urandom);
    if ($urandom_range(0, 4) != 0) return 16'($urandom_range(0, MaxWordsPerSet));
    return 16'($urandom_range(MaxWordsPerSet + 1, 65535));
  endfunction

  task automatic load_node(int node, logic [15:0] set_no, logic [15:0] pairs);
    push_write(FnTrieWr, node, 0, set_no);
    push_write(FnTrieWr, node, 1, pairs);
    for (int c = 2; c < TrieCols; c++) push_write(FnTrieWr, node, c, pick_trie_value(c));
  endtask

  task automatic set_pair(int node, int idx, logic [15:0] sym, logic [15:0] child);
    push_write(FnTrieWr, node, 2 + 2 * idx, sym);
    push_write(FnTrieWr, node, 3 + 2 * idx, child);
  endtask

  task automatic load_set(int set_no, logic [15:0] cnt);
    push_write(FnSugWr, set_no, 0, cnt);
    for (int c = 1; c < SetCols; c++) push_write(FnSugWr, set_no, c, 16'($urandom));
  endtask

  // Hold until every queued word is taken and every result has come back.
  task automatic drain();
    while (words_taken != words_queued || expected_suggestions.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of words with random gaps, fed from pending_words.
  // ---------------------------------------------------------------------------

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        walk_trie(offered);
        words_taken <= words_taken + 1;
        case (offered.func)
          FnKey:    keys_taken++;
          FnCommit: commits_taken++;
          default:  writes_taken++;
        endcase
      end
      // Advance only when the slot is free; a stalled word stays put.
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          offered      = pending_words.pop_front();
          in_valid     <= 1'b1;
          func         <= offered.func;
          key_symbol   <= offered.sym;
          row_index    <= offered.row;
          column_index <= offered.col;
          write_value  <= offered.val;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: modes picked at random, plus one long
  // hold-off once the random part is under way so the block backs up.
  // ---------------------------------------------------------------------------

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && words_taken >= hold_at) begin
      long_hold_done = 1'b1;
      hold_left      = LongHold - 1;
      out_stall      <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'(2'($urandom_range(0, 3)));
        mode_left  = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        StallNone:  out_stall <= 1'b0;
        StallLight: out_stall <= ($urandom_range(0, 3) == 0);
        StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
        default:    out_stall <= (cycle_cnt % 8 < 3);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each taken result with the oldest expectation.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_suggestions.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d word_index %0h last %0b",
                 $time, status, word_index, last);
        mismatch_cnt++;
      end else begin
        exp_res = expected_suggestions.pop_front();
        results_checked++;
        if (status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status);
          mismatch_cnt++;
        end
        if (word_index !== exp_res.word) begin
          $display("%0t: word_index expected %0h actual %0h", $time, exp_res.word,
                   word_index);
          mismatch_cnt++;
        end
        if (last !== exp_res.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_res.last, last);
          mismatch_cnt++;
        end
        case (exp_res.status)
          StSuggest: if (exp_res.last) runs_seen++;
          StNoMatch: no_match_seen++;
          StCommit:  commits_seen++;
          default:   ;
        endcase
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("%0t: timeout with %0d results still expected", $time,
             expected_suggestions.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int fresh;
    int n;
    int c;
    int r;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Build a small trie. The root names no set and carries all eight pairs:
    // a symbol with high bits set ahead of a real match, two bad children, a
    // duplicate symbol that must lose to the first one.
    load_node(NodeRoot, 16'hFFFF, 16'd8);
    set_pair(NodeRoot, 0, 16'h0103, 16'(NodeTop));
    set_pair(NodeRoot, 1, 16'd3, 16'(NodeTop));
    set_pair(NodeRoot, 2, 16'd5, 16'(MaxNodes));
    set_pair(NodeRoot, 3, 16'd6, 16'hFFFF);
    set_pair(NodeRoot, 4, 16'd0, 16'(NodeDead));
    set_pair(NodeRoot, 5, 16'd15, 16'(NodeQuiet));
    set_pair(NodeRoot, 6, 16'd3, 16'(NodeLong));
    set_pair(NodeRoot, 7, 16'd9, 16'(NodeLeaf));
    // Descendant count far above the pair limit: scan clamps to eight.
    load_node(NodeTop, 16'(SetFull), 16'h7FFF);
    set_pair(NodeTop, 0, 16'd1, 16'(NodeLong));
    set_pair(NodeTop, 1, 16'd2, 16'(NodeLeaf));
    for (int i = 2; i < MaxChildren; i++) set_pair(NodeTop, i, 16'hFFFF, pick_child());
    // Set number past the store and a negative descendant count.
    load_node(NodeDead, 16'(MaxSets), 16'h8000);
    load_node(NodeQuiet, 16'(SetEmpty), 16'd1);
    set_pair(NodeQuiet, 0, 16'd4, 16'(NodeRoot));
    load_node(NodeLong, 16'(SetHuge), 16'd2);
    set_pair(NodeLong, 0, 16'd8, 16'(NodeQuiet));
    set_pair(NodeLong, 1, 16'd15, 16'(NodeTop));
    load_node(NodeLeaf, 16'(SetOne), 16'd0);
    load_set(SetOne, 16'd1);
    load_set(SetFull, 16'd16);
    load_set(SetEmpty, 16'd0);
    load_set(SetHuge, 16'hFFFF);

    // Directed walk through the special cases.
    push_commit();            // root has no set: nothing to commit
    push_key(4'd3);           // skip the high-bit symbol, take first match, full set
    push_key(4'd1);           // word count of all ones caps at sixteen
    push_key(4'd8);           // set with zero words
    push_commit();            // nothing to commit, back to root
    push_key(4'd5);           // child just past the store
    push_key(4'd6);           // child with the top bit set
    push_key(4'd0);           // set number past the store
    push_key(4'd11);          // negative count scans nothing
    push_commit();
    push_key(4'd9);           // single-word set
    push_commit();            // commit a word
    push_key(4'd15);
    push_key(4'd4);           // child pointer back to the root
    push_key(4'd12);          // no such symbol at the root
    push_key(4'd3);
    push_key(4'd14);          // clamped scan of eight pairs, no match
    push_commit();
    push_key(4'd3);
    push_key(4'd2);
    push_key(4'd13);          // node with no pairs
    push_write(FnTrieWr, NodeRoot, TrieCols, 16'h5A5A);   // drop: column past the row
    push_write(FnTrieWr, NodeTop, 31, 16'hA5A5);
    push_write(FnSugWr, MaxSets, 0, 16'h0001);            // drop: row past the store
    push_write(FnSugWr, SetOne, SetCols, 16'hFFFF);        // drop: column past the row

    // Let the sender sit until every result of the directed part is back.
    drain();
    hold_at = words_queued + 60;

    // Random part: mostly key runs ended by a commit, with rewrites of live
    // rows and writes that the block must drop mixed in.
    fresh = 0;
    while (fresh < RandomWords) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        n = $urandom_range(1, 4);
        repeat (n) push_key(4'($urandom));
        fresh += n;
        if ($urandom_range(0, 4) != 0) begin
          push_commit();
          fresh++;
        end
      end else if (r < 17) begin
        if ($urandom_range(0, 1) == 1) begin
          c = $urandom_range(0, TrieCols - 1);
          push_write(FnTrieWr, live_nodes[$urandom_range(0, 5)], c, pick_trie_value(c));
        end else begin
          c = $urandom_range(0, SetCols - 1);
          push_write(FnSugWr, live_sets[$urandom_range(0, 3)], c, pick_set_value(c));
        end
        fresh++;
      end else if (r < 19) begin
        if ($urandom_range(0, 1) == 1) begin
          c = $urandom_range(0, TrieCols - 1);
          push_write(FnTrieWr, $urandom_range(0, MaxNodes - 1), c, pick_trie_value(c));
        end else begin
          c = $urandom_range(0, SetCols - 1);
          push_write(FnSugWr, $urandom_range(0, MaxSets - 1), c, pick_set_value(c));
        end
        fresh++;
      end else begin
        case ($urandom_range(0, 2))
          0: push_write(FnTrieWr, $urandom_range(0, 8191), $urandom_range(TrieCols, 31),
                        16'($urandom));
          1: push_write(FnSugWr, $urandom_range(MaxSets, 8191), $urandom_range(0, 31),
                        16'($urandom));
          default: push_write(FnSugWr, $urandom_range(0, MaxSets - 1),
                              $urandom_range(SetCols, 31), 16'($urandom));
        endcase
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk);

    $display("Summary: %0d words taken (%0d keys, %0d commits, %0d table writes), %0d results checked",
             words_taken, keys_taken, commits_taken, writes_taken, results_checked);
    $display("Summary: %0d suggestion runs, %0d no-match, %0d committed words, long hold-off %0s",
             runs_seen, no_match_seen, commits_seen, long_hold_done ? "done" : "missed");
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/kwtp_pkg.sv
rtl/keypad_word_trie_predictor_unit.sv
sim/tb_keypad_word_trie_predictor_unit.sv
